### sv/assert_macros.svh
// assertion macros for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### sv/bp2rgb_pkg.sv
// types and constants for the bit-mask pixel to rgb555 converter
package bp2rgb_pkg;

    localparam int PIX_W     = 32;
    localparam int CH_BITS   = 5;
    localparam int NUM_CH    = 3;
    localparam int DIV_STEPS = CH_BITS;
    localparam int DEN_W     = PIX_W + 1;
    localparam int REM_W     = PIX_W + 6;
    localparam int OUT_W     = NUM_CH * CH_BITS;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASK_BLUE  = 2'd0,
        CFG_MASK_GREEN = 2'd1,
        CFG_MASK_RED   = 2'd2
    } cfg_idx_t;

    localparam logic [PIX_W-1:0] RST_MASK_BLUE  = 32'h0000_00FF;
    localparam logic [PIX_W-1:0] RST_MASK_GREEN = 32'h0000_FF00;
    localparam logic [PIX_W-1:0] RST_MASK_RED   = 32'h00FF_0000;

    typedef logic [NUM_CH-1:0][PIX_W-1:0] masks_t;

    typedef struct packed {
        logic [NUM_CH-1:0][REM_W-1:0]   rem;
        logic [NUM_CH-1:0][DEN_W-1:0]   den;
        logic [NUM_CH-1:0][CH_BITS-1:0] quo;
    } stage_t;

endpackage

### sv/bp2rgb_cfg.sv
// channel mask registers behind the plain write port
module bp2rgb_cfg
    import bp2rgb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [PIX_W-1:0]     wr_data,
    output masks_t               masks
);

    masks_t masks_reg;
    masks_t masks_next;

    always_comb
    begin
        masks_next = masks_reg;
        if (wr_en)
        begin
            unique case (cfg_idx_t'(wr_index))
                CFG_MASK_BLUE:  masks_next[0] = wr_data;
                CFG_MASK_GREEN: masks_next[1] = wr_data;
                CFG_MASK_RED:   masks_next[2] = wr_data;
                default:        masks_next = masks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            masks_reg[0] <= RST_MASK_BLUE;
            masks_reg[1] <= RST_MASK_GREEN;
            masks_reg[2] <= RST_MASK_RED;
        end
        else
        begin
            masks_reg <= masks_next;
        end
    end

    assign masks = masks_reg;

endmodule

### sv/bp2rgb_front.sv
// input stage: masked field, rounding numerator and divisor per channel
module bp2rgb_front
    import bp2rgb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             in_valid,
    input  logic [PIX_W-1:0] pixel_word,
    input  masks_t           masks,
    output logic             stage_valid,
    output stage_t           stage_data
);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;

    // field and mask share the same shift, so the ratio needs no alignment
    always_comb
    begin
        logic [PIX_W-1:0] field;
        for (int c = 0; c < NUM_CH; c++)
        begin
            field = pixel_word & masks[c];
            data_next.rem[c] = {field, 6'b0} - {5'b0, field, 1'b0}
                               + {6'b0, masks[c]};
            // zero mask: numerator is zero, any non-zero divisor yields zero
            if (masks[c] == '0)
                data_next.den[c] = DEN_W'(1);
            else
                data_next.den[c] = {masks[c], 1'b0};
            data_next.quo[c] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= data_next;
    end

    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

endmodule

### sv/bp2rgb_divstep.sv
// one restoring division step for all three channels, one quotient bit each
module bp2rgb_divstep
    import bp2rgb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  logic   in_valid,
    input  stage_t in_data,
    output logic   stage_valid,
    output stage_t stage_data
);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;

    always_comb
    begin
        logic [REM_W-1:0] dsh;
        logic [REM_W-1:0] rem;
        logic             ge;
        data_next = in_data;
        for (int c = 0; c < NUM_CH; c++)
        begin
            dsh = {1'b0, in_data.den[c], 4'b0};
            ge  = (in_data.rem[c] >= dsh);
            rem = ge ? (in_data.rem[c] - dsh) : in_data.rem[c];
            data_next.rem[c] = {rem[REM_W-2:0], 1'b0};
            data_next.quo[c] = {in_data.quo[c][CH_BITS-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= data_next;
    end

    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

endmodule

### sv/bitmask_pixel_to_rgb555.sv
// top level: bit-mask pixel word to rgb555 converter
// an accepted beat reaches its result through the input stage register and then the divider step registers
// one beat per cycle unless the result register is stalled; the pipe is one input stage and five divider steps
// the whole pipe holds while the result register is stalled
// reset clears all valid bits and loads the default 8-bit masks
module bitmask_pixel_to_rgb555
    import bp2rgb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [PIX_W-1:0]     wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PIX_W-1:0]     pixel_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [OUT_W-1:0]     rgb555
);

`include "assert_macros.svh"

    masks_t              masks;
    logic                advance;
    logic [DIV_STEPS:0]  stg_valid;
    stage_t              stg_data [DIV_STEPS+1];

    bp2rgb_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .masks    (masks)
    );

    bp2rgb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (in_valid),
        .pixel_word  (pixel_word),
        .masks       (masks),
        .stage_valid (stg_valid[0]),
        .stage_data  (stg_data[0])
    );

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_div
        bp2rgb_divstep u_step (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (advance),
            .in_valid    (stg_valid[s]),
            .in_data     (stg_data[s]),
            .stage_valid (stg_valid[s+1]),
            .stage_data  (stg_data[s+1])
        );
    end

    assign advance   = !(stg_valid[DIV_STEPS] && out_stall);
    assign in_stall  = !advance;
    assign out_valid = stg_valid[DIV_STEPS];
    assign rgb555    = stg_data[DIV_STEPS].quo;

    // remainder left by the last step stays below the shifted divisor
    `ASSERT_IMPLIES(a_rem_bound, clk, rst_n, out_valid,
        (stg_data[DIV_STEPS].rem[0] < {stg_data[DIV_STEPS].den[0], 5'b0}) &&
        (stg_data[DIV_STEPS].rem[1] < {stg_data[DIV_STEPS].den[1], 5'b0}) &&
        (stg_data[DIV_STEPS].rem[2] < {stg_data[DIV_STEPS].den[2], 5'b0}))
    // a zero blue mask reaches the output as a zero blue channel
    `ASSERT_IMPLIES(a_zero_mask, clk, rst_n,
        out_valid && (stg_data[DIV_STEPS].den[0] == DEN_W'(1)),
        stg_data[DIV_STEPS].quo[0] == '0)
    // a held pipe keeps every valid bit
    `ASSERT_NEXT(a_hold_valid, clk, rst_n, !advance, $stable(stg_valid))

endmodule

### tb/rgb555_checker.sv
`timescale 1ns / 100ps
// beat checker for the rgb555 converter: tracks mask writes, predicts each result and compares
module rgb555_checker
    import bp2rgb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [PIX_W-1:0]     wr_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [PIX_W-1:0]     pixel_word,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [OUT_W-1:0]     rgb555,
    output int                   mismatches,
    output int                   pending
);

    localparam int CH_FULL = (1 << CH_BITS) - 1;

    logic [PIX_W-1:0] blue_mask;
    logic [PIX_W-1:0] green_mask;
    logic [PIX_W-1:0] red_mask;
    logic [OUT_W-1:0] expected_rgb[$];

    // round(field * 31 / full) with ties up; a zero mask gives zero
    function automatic logic [CH_BITS-1:0] channel_level(input logic [PIX_W-1:0] pix,
                                                         input logic [PIX_W-1:0] mask);
        int unsigned      sh;
        logic [PIX_W-1:0] field;
        logic [PIX_W-1:0] full;
        logic [63:0]      num;
        logic [63:0]      den;
        if (mask == '0)
            return '0;
        sh = 0;
        while (sh < PIX_W - 1 && !mask[sh])
            sh++;
        field = (pix & mask) >> sh;
        full  = mask >> sh;
        num   = 64'(field) * 64'(2 * CH_FULL) + 64'(full);
        den   = 64'(full) * 64'd2;
        return CH_BITS'(num / den);
    endfunction

    function automatic logic [OUT_W-1:0] rgb555_of(input logic [PIX_W-1:0] pix);
        return {channel_level(pix, red_mask),
                channel_level(pix, green_mask),
                channel_level(pix, blue_mask)};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [OUT_W-1:0] want;
        if (!rst_n)
        begin
            blue_mask  = RST_MASK_BLUE;
            green_mask = RST_MASK_GREEN;
            red_mask   = RST_MASK_RED;
            expected_rgb.delete();
            pending    <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    CFG_MASK_BLUE:  blue_mask  = wr_data;
                    CFG_MASK_GREEN: green_mask = wr_data;
                    CFG_MASK_RED:   red_mask   = wr_data;
                    default:        ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_rgb.size() == 0)
                begin
                    $display("%0t: rgb555 beat with none expected, expected nothing, got %h",
                             $time, rgb555);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_rgb.pop_front();
                    if (rgb555 !== want)
                    begin
                        $display("%0t: rgb555 mismatch, expected %h, got %h",
                                 $time, want, rgb555);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_rgb.push_back(rgb555_of(pixel_word));
            pending <= expected_rgb.size();
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// testbench top for the rgb555 converter: clock, reset, mask phases, pixel stimulus and verdict
module tb;
    import bp2rgb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BEATS   = 104;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_AT_BEAT  = 400;
    localparam int HOLD_CYCLES   = 64;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_t;
    typedef enum {MASK_ZERO, MASK_ALL, MASK_ONE_BIT, MASK_SCATTER, MASK_FIELD} mask_style_t;

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [PIX_W-1:0]     wr_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [PIX_W-1:0]     pixel_word;
    logic                 out_valid;
    logic                 out_stall;
    logic [OUT_W-1:0]     rgb555;

    int               mismatches;
    int               pending;
    int               sent_beats;
    int               burst_left;
    bit               held_long;
    logic [PIX_W-1:0] cur_blue;
    logic [PIX_W-1:0] cur_green;
    logic [PIX_W-1:0] cur_red;

    bitmask_pixel_to_rgb555 dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_word (pixel_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rgb555     (rgb555)
    );

    rgb555_checker conv_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_word (pixel_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rgb555     (rgb555),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // receiver: segments of differing stall density, plus one long hold-off
    initial
    begin : receiver
        int          seg_len;
        stall_mode_t mode;
        out_stall = 1'b0;
        held_long = 1'b0;
        forever
        begin
            if (!held_long && sent_beats >= HOLD_AT_BEAT)
            begin
                held_long = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            seg_len = $urandom_range(40, 4);
            mode    = stall_mode_t'($urandom_range(3, 0));
            repeat (seg_len)
            begin
                unique case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(3, 0) == 0);
                    STALL_HALF:  out_stall <= ($urandom_range(1, 0) == 0);
                    default:     out_stall <= ($urandom_range(3, 0) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(24, 1);
            gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        pixel_word <= pix;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_beats++;
    endtask

    task automatic drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_masks(input logic [PIX_W-1:0] blue, input logic [PIX_W-1:0] green,
                              input logic [PIX_W-1:0] red, input bit poke_unused);
        drain();
        wr_en    <= 1'b1;
        wr_index <= CFG_MASK_BLUE;
        wr_data  <= blue;
        @(posedge clk);
        wr_index <= CFG_MASK_GREEN;
        wr_data  <= green;
        @(posedge clk);
        wr_index <= CFG_MASK_RED;
        wr_data  <= red;
        @(posedge clk);
        if (poke_unused)
        begin
            wr_index <= CFG_UNUSED;
            wr_data  <= $urandom();
            @(posedge clk);
        end
        wr_en     <= 1'b0;
        cur_blue  = blue;
        cur_green = green;
        cur_red   = red;
    endtask

    function automatic logic [PIX_W-1:0] random_mask();
        mask_style_t style;
        logic [63:0] ones;
        int          lsb;
        int          width;
        style = ($urandom_range(9, 0) < 4) ? mask_style_t'($urandom_range(3, 0)) : MASK_FIELD;
        unique case (style)
            MASK_ZERO:    return '0;
            MASK_ALL:     return '1;
            MASK_ONE_BIT: return PIX_W'(1) << $urandom_range(PIX_W - 1, 0);
            MASK_SCATTER: return $urandom();
            default:
            begin
                lsb   = $urandom_range(PIX_W - 1, 0);
                width = $urandom_range(PIX_W - lsb, 1);
                ones  = (64'd1 << width) - 64'd1;
                return PIX_W'(ones << lsb);
            end
        endcase
    endfunction

    // full-scale and empty fields turn up often
    function automatic logic [PIX_W-1:0] random_pixel();
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] all_masks;
        pix       = $urandom();
        all_masks = cur_blue | cur_green | cur_red;
        unique case ($urandom_range(7, 0))
            0:       return pix | all_masks;
            1:       return pix & ~all_masks;
            2:       return pix | cur_blue;
            3:       return pix | cur_green;
            4:       return pix | cur_red;
            default: return pix;
        endcase
    endfunction

    initial
    begin : stimulus
        rst_n      = 1'b0;
        wr_en      = 1'b0;
        wr_index   = CFG_MASK_BLUE;
        wr_data    = '0;
        in_valid   = 1'b0;
        pixel_word = '0;
        sent_beats = 0;
        burst_left = 0;
        cur_blue   = RST_MASK_BLUE;
        cur_green  = RST_MASK_GREEN;
        cur_red    = RST_MASK_RED;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default 8-bit masks straight out of reset
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h00FF_FFFF);
        send_pixel(32'hFF00_0000);
        send_pixel(32'h0080_8080);
        send_pixel(32'h007F_7F7F);
        send_pixel(32'h0001_0203);
        send_pixel(32'h00FE_FDFC);
        send_pixel(32'hAA55_AA55);

        // full-width, zero and top-bit masks, plus a write to the unused index
        load_masks(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 1'b1);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h8000_0000);
        send_pixel(32'h7FFF_FFFF);
        send_pixel(32'h0000_0001);
        send_pixel(32'h8421_0842);

        // mask with gaps, a 5-bit field and a one-bit field
        load_masks(32'h0000_0505, 32'h0001_F000, 32'h0000_0001, 1'b0);
        send_pixel(32'h0000_0505);
        send_pixel(32'h0000_0500);
        send_pixel(32'h0001_F000);
        send_pixel(32'h0000_A000);
        send_pixel(32'hFFFF_FAFA);
        send_pixel(32'h0000_1001);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            load_masks(random_mask(), random_mask(), random_mask(),
                       1'($urandom_range(1, 0)));
            repeat (PHASE_BEATS)
                send_pixel(random_pixel());
        end

        drain();
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
